FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, also while reset is held.
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked on every rising edge of clk outside reset.
`define CHK_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: hdl/chse_pkg.sv
package chse_pkg;

  localparam logic [3:0] PIU_RESET = 4'd7;
  localparam logic signed [23:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] VAL_MIN = 24'sh800000;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef struct packed {
    logic is_eval;
    logic slot_ok;
    logic [2:0] idx;
    logic signed [15:0] pos;
    logic signed [23:0] val;
    logic signed [23:0] slp;
    logic signed [15:0] smp;
  } item_t;

  typedef struct packed {
    logic valid;
    item_t item;
  } queue_head_t;

endpackage

FILE: hdl/chse_front.sv
module chse_front import chse_pkg::*; #(
  parameter int MAX_POINTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,
  input  logic        in_tuser,
  input  logic        pop,
  output queue_head_t head
);

  logic [1:0] cnt_r, cnt_nxt;
  item_t slot0_r, slot1_r, item_new;
  logic push;

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready;

  always_comb begin
    item_new.is_eval = (in_tuser == CMD_EVAL);
    item_new.idx = in_tdata[2:0];
    item_new.slot_ok = (int'(in_tdata[2:0]) < MAX_POINTS);
    item_new.pos = in_tdata[18:3];
    item_new.val = in_tdata[42:19];
    item_new.slp = in_tdata[66:43];
    item_new.smp = in_tdata[82:67];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop))) begin
      slot0_r <= item_new;
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
    if (push && ((cnt_r == 2'd1 && !pop) || (cnt_r == 2'd2 && pop))) begin
      slot1_r <= item_new;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item = slot0_r;

endmodule

FILE: hdl/chse_div.sv
module chse_div import chse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [31:0] quo
);

  logic busy_r, done_r;
  logic [4:0] cnt_r;
  logic [31:0] sh_r;
  logic [15:0] rem_r, den_r;
  logic [16:0] trial;
  logic fits;

  assign trial = {rem_r, sh_r[31]};
  assign fits = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 5'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r <= num;
      den_r <= den;
      rem_r <= 16'd0;
    end else if (busy_r) begin
      sh_r <= {sh_r[30:0], fits};
      rem_r <= fits ? 16'(trial - {1'b0, den_r}) : trial[15:0];
    end
  end

  assign done = done_r;
  assign quo = sh_r;

endmodule

FILE: hdl/chse_back.sv
module chse_back import chse_pkg::*; #(
  parameter int MAX_POINTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  queue_head_t head,
  output logic        pop,
  input  logic [3:0]  points_in_use,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tuser
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_FIRST = 18'h00002,
    S_LAST  = 18'h00004,
    S_SCAN  = 18'h00008,
    S_DIVS  = 18'h00010,
    S_DIVW  = 18'h00020,
    S_T2    = 18'h00040,
    S_T3    = 18'h00080,
    S_S0    = 18'h00100,
    S_S1    = 18'h00200,
    S_HB    = 18'h00400,
    S_A0    = 18'h00800,
    S_A1    = 18'h01000,
    S_A2    = 18'h02000,
    S_A3    = 18'h04000,
    S_FIN   = 18'h08000,
    S_RES   = 18'h10000,
    S_OUT   = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  logic [63:0] mem [MAX_POINTS];
  logic [63:0] mem_q_r;
  logic [AW-1:0] rd_addr, nlast, j_r;
  logic [NW-1:0] n;

  logic signed [15:0] smp_r, pos0_r, pos1_r, q_pos;
  logic signed [23:0] val0_r, val1_r, slp0_r, slp1_r, q_val, q_slp;
  logic signed [16:0] dx, diff;
  logic [16:0] t_r;
  logic [33:0] t2_r;
  logic [48:0] t3_r;
  logic signed [25:0] sd0_r, sd1_r, sd_new;
  logic signed [31:0] h00_r, h10_r, h01_r, h11_r;
  logic signed [34:0] ma;
  logic signed [25:0] mb;
  logic signed [60:0] prod_r, acc_r, rs15, ysum;
  logic signed [30:0] yv;
  logic signed [53:0] t3w, t2s, tsh, h00w, h10w, h01w, h11w;
  logic signed [23:0] res_r, out_data_r;
  logic sat_r, out_sat_r, out_valid_r;
  logic div_start, div_done;
  logic [31:0] div_quo;
  logic found, load_out;

  always_comb begin
    if (points_in_use < 4'd2) begin
      n = NW'(2);
    end else if (int'(points_in_use) > MAX_POINTS) begin
      n = NW'(MAX_POINTS);
    end else begin
      n = NW'(points_in_use);
    end
  end
  assign nlast = AW'(n - NW'(1));

  assign q_pos = mem_q_r[63:48];
  assign q_val = mem_q_r[47:24];
  assign q_slp = mem_q_r[23:0];

  assign pop = (state_r == S_IDLE) && head.valid;

  always_comb begin
    case (state_r)
      S_FIRST: rd_addr = nlast;
      S_LAST:  rd_addr = AW'(1);
      S_SCAN:  rd_addr = AW'(j_r + AW'(1));
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && head.item.is_eval == CMD_WRITE && head.item.slot_ok) begin
      mem[AW'(head.item.idx)] <= {head.item.pos, head.item.val, head.item.slp};
    end
    mem_q_r <= mem[rd_addr];
  end

  assign dx = 17'(pos1_r) - 17'(pos0_r);
  assign diff = 17'(smp_r) - 17'(pos0_r);
  assign div_start = (state_r == S_DIVS);
  assign found = (q_pos >= smp_r);

  chse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({diff[15:0], 16'd0}),
    .den   (dx[15:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    case (state_r)
      S_T2: begin
        ma = $signed({18'd0, t_r});
        mb = $signed({9'd0, t_r});
      end
      S_T3: begin
        ma = $signed({1'b0, prod_r[33:0]});
        mb = $signed({9'd0, t_r});
      end
      S_S0: begin
        ma = 35'(slp0_r);
        mb = 26'(dx);
      end
      S_S1: begin
        ma = 35'(slp1_r);
        mb = 26'(dx);
      end
      S_A0: begin
        ma = 35'(h00_r);
        mb = 26'(val0_r);
      end
      S_A1: begin
        ma = 35'(h10_r);
        mb = sd0_r;
      end
      S_A2: begin
        ma = 35'(h01_r);
        mb = 26'(val1_r);
      end
      S_A3: begin
        ma = 35'(h11_r);
        mb = sd1_r;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign rs15 = prod_r + 61'sd16384;
  assign sd_new = rs15[40:15];

  assign t3w = $signed({5'd0, t3_r});
  assign t2s = $signed({4'd0, t2_r, 16'd0});
  assign tsh = $signed({5'd0, t_r, 32'd0});
  assign h00w = (t3w <<< 1) - (t2s + (t2s <<< 1)) + 54'sh1000000000000 + 54'sd131072;
  assign h10w = t3w - (t2s <<< 1) + tsh + 54'sd131072;
  assign h01w = (t2s + (t2s <<< 1)) - (t3w <<< 1) + 54'sd131072;
  assign h11w = t3w - t2s + 54'sd131072;

  assign ysum = acc_r + 61'sd536870912;
  assign yv = $signed(ysum[60:30]);

  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (pop && head.item.is_eval == CMD_EVAL) begin
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: state_nxt = (smp_r <= q_pos) ? S_OUT : S_LAST;
      S_LAST:  state_nxt = (smp_r >= q_pos) ? S_OUT : S_SCAN;
      S_SCAN:  state_nxt = found ? S_DIVS : S_SCAN;
      S_DIVS:  state_nxt = S_DIVW;
      S_DIVW:  state_nxt = div_done ? S_T2 : S_DIVW;
      S_T2:    state_nxt = S_T3;
      S_T3:    state_nxt = S_S0;
      S_S0:    state_nxt = S_S1;
      S_S1:    state_nxt = S_HB;
      S_HB:    state_nxt = S_A0;
      S_A0:    state_nxt = S_A1;
      S_A1:    state_nxt = S_A2;
      S_A2:    state_nxt = S_A3;
      S_A3:    state_nxt = S_FIN;
      S_FIN:   state_nxt = S_RES;
      S_RES:   state_nxt = S_OUT;
      S_OUT:   state_nxt = load_out ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    if (load_out) begin
      out_data_r <= res_r;
      out_sat_r <= sat_r;
    end
    case (state_r)
      S_IDLE: smp_r <= head.item.smp;
      S_FIRST: begin
        pos0_r <= q_pos;
        val0_r <= q_val;
        slp0_r <= q_slp;
        res_r <= q_val;
        sat_r <= 1'b0;
      end
      S_LAST: begin
        res_r <= q_val;
        sat_r <= 1'b0;
        j_r <= AW'(1);
      end
      S_SCAN: begin
        if (found) begin
          pos1_r <= q_pos;
          val1_r <= q_val;
          slp1_r <= q_slp;
        end else begin
          pos0_r <= q_pos;
          val0_r <= q_val;
          slp0_r <= q_slp;
          j_r <= AW'(j_r + AW'(1));
        end
      end
      S_DIVW: begin
        if (div_quo > 32'd65536) begin
          t_r <= 17'd65536;
        end else begin
          t_r <= div_quo[16:0];
        end
      end
      S_T3: t2_r <= prod_r[33:0];
      S_S0: t3_r <= prod_r[48:0];
      S_S1: sd0_r <= sd_new;
      S_HB: begin
        sd1_r <= sd_new;
        h00_r <= h00w[49:18];
        h10_r <= h10w[49:18];
        h01_r <= h01w[49:18];
        h11_r <= h11w[49:18];
      end
      S_A1: acc_r <= prod_r;
      S_A2: acc_r <= acc_r + prod_r;
      S_A3: acc_r <= acc_r + prod_r;
      S_FIN: acc_r <= acc_r + prod_r;
      S_RES: begin
        if (yv > 31'(VAL_MAX)) begin
          res_r <= VAL_MAX;
          sat_r <= 1'b1;
        end else if (yv < 31'(VAL_MIN)) begin
          res_r <= VAL_MIN;
          sat_r <= 1'b1;
        end else begin
          res_r <= yv[23:0];
          sat_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_sat_r;

endmodule

FILE: hdl/cubic_hermite_spline_eval.sv
// Channel  Direction  tdata (low bit up)                                  tuser
// in_      slave      point_index, point_position, point_value,           command
//                     point_slope, sample, zero fill to 88 bits
// out_     master     curve_value                                         saturated
// cfg_     write      points_in_use                                       -
//
// A write word goes into the point table without starting the evaluator. An
// evaluate word that clamps at the first or the last point skips the divider;
// an interior one scans the points in order and spends most of its time in the
// one-bit-per-cycle divider that forms t.
// Reset is synchronous; the point table is not cleared.
// A two-word queue takes input while the evaluator is busy, and an output
// register holds a finished word while the evaluator starts the next one.
`include "assert_macros.svh"

module cubic_hermite_spline_eval import chse_pkg::*; #(
  parameter int MAX_POINTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // point_index, point_position, point_value, point_slope, sample
  input  logic [87:0] in_tdata,
  // command
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // curve_value
  output logic [23:0] out_tdata,
  // saturated
  output logic        out_tuser,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);

  logic [3:0] points_in_use_r;
  queue_head_t head;
  logic pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_in_use_r <= PIU_RESET;
    end else if (cfg_wr_en) begin
      points_in_use_r <= cfg_wr_data;
    end
  end

  chse_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .pop       (pop),
    .head      (head)
  );

  chse_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (pop),
    .points_in_use (points_in_use_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser)
  );

  `CHK_ALWAYS(a_reset_out, !rst_n |=> !out_tvalid, "output valid after reset")
  `CHK_RUN(a_sat_extreme,
           out_tvalid && out_tuser |-> (out_tdata == VAL_MAX || out_tdata == VAL_MIN),
           "saturated word is not at a range limit")
  `CHK_RUN(a_full_queue, !in_tready |-> head.valid, "input stalled with empty queue")
  `CHK_RUN(a_pop_valid, pop |-> head.valid, "queue popped while empty")

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb import chse_pkg::*; ();

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // point_index, point_position, point_value, point_slope, sample
  logic [87:0] in_tdata;
  // command
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // curve_value
  logic [23:0] out_tdata;
  // saturated
  logic        out_tuser;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;

  cubic_hermite_spline_eval u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  typedef struct {
    logic [23:0] curve;
    logic        sat;
  } curve_result_t;

  logic signed [15:0] tbl_pos [8];
  logic signed [23:0] tbl_val [8];
  logic signed [23:0] tbl_slp [8];
  logic [3:0]         points_cfg;
  curve_result_t      expected_curves [$];
  int                 errors = 0;
  int                 idle_cycles = 0;
  int                 send_idle_pct;
  int                 recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_half(longint x, int k);
    return (x + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic curve_result_t hermite_curve(logic signed [15:0] smp);
    curve_result_t r;
    int n, seg;
    longint s, x0, x1, dx, t, t2, t3, h00, h10, h01, h11, sd0, sd1, acc, y;
    n = (points_cfg < 2) ? 2 : ((points_cfg > 8) ? 8 : points_cfg);
    s = smp;
    r.sat = 1'b0;
    if (s <= tbl_pos[0]) begin
      y = tbl_val[0];
    end else if (s >= tbl_pos[n-1]) begin
      y = tbl_val[n-1];
    end else begin
      seg = 0;
      for (int j = n - 1; j >= 1; j--) begin
        if (tbl_pos[j] >= s) seg = j - 1;
      end
      x0 = tbl_pos[seg];
      x1 = tbl_pos[seg+1];
      dx = x1 - x0;
      t = ((s - x0) <<< 16) / dx;
      if (t > 65536) t = 65536;
      t2 = t * t;
      t3 = t2 * t;
      h00 = round_half(2 * t3 - 3 * (t2 <<< 16) + (longint'(1) <<< 48), 18);
      h10 = round_half(t3 - 2 * (t2 <<< 16) + (t <<< 32), 18);
      h01 = round_half(-2 * t3 + 3 * (t2 <<< 16), 18);
      h11 = round_half(t3 - (t2 <<< 16), 18);
      sd0 = round_half(longint'(tbl_slp[seg]) * dx, 15);
      sd1 = round_half(longint'(tbl_slp[seg+1]) * dx, 15);
      acc = h00 * tbl_val[seg] + h10 * sd0 + h01 * tbl_val[seg+1] + h11 * sd1;
      y = round_half(acc, 30);
      if (y > 8388607) begin
        y = 8388607;
        r.sat = 1'b1;
      end
      if (y < -8388608) begin
        y = -8388608;
        r.sat = 1'b1;
      end
    end
    r.curve = y[23:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    errors++;
    $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    curve_result_t w;
    if (rst_n && (in_tvalid && in_tready || out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_curves.size() == 0) begin
        report_mismatch("unexpected word", out_tdata, 24'h0);
      end else begin
        w = expected_curves.pop_front();
        if (out_tdata !== w.curve) report_mismatch("curve_value", out_tdata, w.curve);
        if (out_tuser !== w.sat)
          report_mismatch("saturated", {23'd0, out_tuser}, {23'd0, w.sat});
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles > 20000) begin
      $display("FAIL cubic_hermite_spline_eval");
      $finish;
    end
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_word(input logic cmd, input logic [2:0] idx,
                           input logic [15:0] pos, input logic [23:0] val,
                           input logic [23:0] slp, input logic [15:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {8'd0, smp, slp, val, pos, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_WRITE) begin
      tbl_pos[idx] = pos;
      tbl_val[idx] = val;
      tbl_slp[idx] = slp;
    end else begin
      expected_curves.push_back(hermite_curve(smp));
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_curves.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_points_in_use(input logic [3:0] n);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    points_cfg = n;
  endtask

  // Ascending positions with random gaps, values and slopes.
  task automatic load_sorted_table(input logic big);
    int p;
    p = -32768 + $urandom_range(4000);
    for (int i = 0; i < 8; i++) begin
      send_word(CMD_WRITE, i[2:0], p[15:0],
                big ? 24'($urandom()) : 24'($signed($urandom_range(65535)) - 32768),
                big ? 24'($urandom()) : 24'($signed($urandom_range(65535)) - 32768),
                16'($urandom()));
      p = p + 1 + $urandom_range(8000);
      if (p > 32767) p = 32767;
    end
  endtask

  task automatic eval_random(input int count);
    for (int k = 0; k < count; k++) begin
      send_word(CMD_EVAL, 3'($urandom()), 16'($urandom()), 24'($urandom()),
                24'($urandom()),
                ($urandom_range(9) == 0) ? 16'($urandom_range(1) ? 16'h7FFF : 16'h8000)
                                         : 16'($urandom()));
    end
  endtask

  task automatic test_directed();
    send_word(CMD_WRITE, 3'd0, 16'h8000, 24'h800000, 24'h7FFFFF, 16'hFFFF);
    send_word(CMD_WRITE, 3'd1, 16'h8001, 24'h7FFFFF, 24'h800000, 16'h0000);
    send_word(CMD_WRITE, 3'd2, 16'h0000, 24'h7FFFFF, 24'h7FFFFF, 16'h0);
    send_word(CMD_WRITE, 3'd3, 16'h4000, 24'h800000, 24'h800000, 16'h0);
    send_word(CMD_WRITE, 3'd4, 16'h4001, 24'h001000, 24'h000000, 16'h0);
    send_word(CMD_WRITE, 3'd5, 16'h6000, 24'hFFF000, 24'h001000, 16'h0);
    send_word(CMD_WRITE, 3'd6, 16'h7FFE, 24'h000000, 24'hFFFFFF, 16'h0);
    send_word(CMD_WRITE, 3'd7, 16'h7FFF, 24'h123456, 24'h654321, 16'h0);
    send_word(CMD_EVAL, 3'd7, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'h8000);
    send_word(CMD_EVAL, 3'd0, 16'h0, 24'h0, 24'h0, 16'h8001);
    send_word(CMD_EVAL, 3'd0, 16'h0, 24'h0, 24'h0, 16'hC000);
    send_word(CMD_EVAL, 3'd0, 16'h0, 24'h0, 24'h0, 16'h0000);
    send_word(CMD_EVAL, 3'd0, 16'h0, 24'h0, 24'h0, 16'h2000);
    send_word(CMD_EVAL, 3'd0, 16'h0, 24'h0, 24'h0, 16'h4001);
    send_word(CMD_EVAL, 3'd0, 16'h0, 24'h0, 24'h0, 16'h7FFF);
    send_word(CMD_EVAL, 3'd0, 16'h0, 24'h0, 24'h0, 16'h7000);
    write_points_in_use(4'd8);
    send_word(CMD_EVAL, 3'd0, 16'h0, 24'h0, 24'h0, 16'h7FFF);
    send_word(CMD_EVAL, 3'd0, 16'h0, 24'h0, 24'h0, 16'h7FFE);
    write_points_in_use(4'd0);
    send_word(CMD_EVAL, 3'd0, 16'h0, 24'h0, 24'h0, 16'h8000);
    send_word(CMD_EVAL, 3'd0, 16'h0, 24'h0, 24'h0, 16'h8001);
    write_points_in_use(4'd15);
    send_word(CMD_EVAL, 3'd0, 16'h0, 24'h0, 24'h0, 16'h7FFF);
    send_word(CMD_EVAL, 3'd0, 16'h0, 24'h0, 24'h0, 16'h5000);
  endtask

  // Unsorted tables still keep x0 < sample <= x1 by construction.
  task automatic test_random_phase(input int rounds);
    for (int r = 0; r < rounds; r++) begin
      write_points_in_use(4'($urandom_range(15)));
      if ($urandom_range(3) == 0) begin
        for (int i = 0; i < 8; i++)
          send_word(CMD_WRITE, i[2:0], 16'($urandom()), 24'($urandom()),
                    24'($urandom()), 16'($urandom()));
      end else begin
        load_sorted_table(1'($urandom_range(1)));
      end
      eval_random(40);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    points_cfg = PIU_RESET;
    send_idle_pct = 20;
    recv_stall_pct = 52;
    for (int i = 0; i < 8; i++) begin
      tbl_pos[i] = '0;
      tbl_val[i] = '0;
      tbl_slp[i] = '0;
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_phase(11);
    send_idle_pct = 52;
    recv_stall_pct = 20;
    test_random_phase(11);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_phase(11);
    drain_results();
    if (errors == 0)
      $display("PASS cubic_hermite_spline_eval");
    else
      $display("FAIL cubic_hermite_spline_eval");
    $finish;
  end

endmodule

FILE: cubic_hermite_spline_eval.f
+incdir+hdl
hdl/chse_pkg.sv
hdl/chse_front.sv
hdl/chse_div.sv
hdl/chse_back.sv
hdl/cubic_hermite_spline_eval.sv
sim/tb.sv
